[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

[hw/rtl/cfr_pkg.sv]
`default_nettype none

package cfr_pkg;

  localparam int unsigned NUM_FRAMES = 64;
  localparam int unsigned FRAME_BITS = 6;
  localparam int unsigned PAGE_BITS  = 20;
  localparam int unsigned OWNER_BITS = 8;

  // free-frame search looks at one group of frames per cycle
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned GROUP_BITS = 3;
  localparam int unsigned NUM_GROUPS = NUM_FRAMES / GROUP_SIZE;
  localparam int unsigned GSEL_BITS  = FRAME_BITS - GROUP_BITS;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [FRAME_BITS-1:0] frame_index;
    logic [PAGE_BITS-1:0]  page_number;
    logic [OWNER_BITS-1:0] owner_id;
  } cfr_req_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] granted_frame;
    logic                  evicted;
    logic [PAGE_BITS-1:0]  victim_page;
    logic [OWNER_BITS-1:0] victim_owner;
    logic                  status;
  } cfr_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/clock_frame_replacement.sv]
// Frame table with second-chance (clock) replacement.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request beat per
// action: allocate a frame for (page, owner), free a frame, or mark a frame
// accessed. Output channel (out_valid_o / out_stall_i / out_data_o): exactly
// one result beat per request, in request order.
// One request is worked at a time; the next one is taken as soon as the
// engine is idle, even while the previous result still waits in the output
// register.
// Work per request, accept to next accept with the receiver keeping up:
//   free / mark / unused code : S_OP only, result loaded from there
//   allocate, a frame free    : group scan, then S_FINISH
//                               (lowest free frame, 8 frames a cycle)
//   allocate with eviction    : full group scan, then clock sweep (one frame
//                               a cycle, page/owner RAM read registered)
// The sweep over the reference bits sets the worst case.
// Reset (rst_ni low, async) clears all used and reference bits and the clock
// hand; the page/owner RAM is not cleared and needs no clearing pass.
// When the receiver stalls, the result is held and a finished request waits
// in its last state until the output register frees up.
`default_nettype none

`include "assert_macros.svh"

module clock_frame_replacement
  import cfr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cfr_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cfr_rsp_t      out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a request
    S_OP,      // free / mark / unused code
    S_SCAN,    // search for the lowest free frame
    S_SWEEP,   // clock sweep, all frames in use
    S_FINISH   // install page, emit allocate result
  } state_e;

  localparam int unsigned ENTRY_BITS = PAGE_BITS + OWNER_BITS;

  state_e                state_q;
  cfr_req_t              req_q;
  cfr_rsp_t              rsp_q;
  logic                  out_valid_q;
  logic [NUM_FRAMES-1:0] used_q;
  logic [NUM_FRAMES-1:0] ref_q;
  logic [FRAME_BITS-1:0] hand_q;
  logic [FRAME_BITS-1:0] victim_q;
  logic                  evict_q;
  logic [GSEL_BITS-1:0]  grp_q;

  // page/owner store: one write port, one registered read port
  logic [ENTRY_BITS-1:0] mem_q [NUM_FRAMES];
  logic [ENTRY_BITS-1:0] rd_q;
  logic                  mem_we;
  logic                  mem_re;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic [FRAME_BITS-1:0] hand_nxt;
  logic [FRAME_BITS-1:0] victim_nxt;
  logic [GROUP_SIZE-1:0] grp_used;
  logic                  grp_hit;
  logic [GROUP_BITS-1:0] grp_sel;
  logic                  op_fault;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;
  // output register can take a new beat this cycle
  assign out_free    = !out_valid_q || !out_stall_i;
  // a result beat is loaded this cycle
  assign out_load    = ((state_q == S_OP) || (state_q == S_FINISH)) && out_free;

  always_comb begin
    hand_nxt   = (hand_q == FRAME_BITS'(NUM_FRAMES - 1)) ? '0 : hand_q + 1'b1;
    victim_nxt = (victim_q == FRAME_BITS'(NUM_FRAMES - 1)) ? '0 : victim_q + 1'b1;
    grp_used   = used_q[grp_q * GROUP_SIZE +: GROUP_SIZE];
    grp_hit    = !(&grp_used);
    grp_sel    = '0;
    // lowest clear bit in the group
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (!grp_used[i]) grp_sel = GROUP_BITS'(i);
    end
    op_fault = !used_q[req_q.frame_index];
    mem_re   = (state_q == S_SWEEP) && !ref_q[hand_nxt];
    mem_we   = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[victim_q] <= {req_q.page_number, req_q.owner_id};
    if (mem_re) rd_q <= mem_q[hand_nxt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      rsp_q       <= '0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      ref_q       <= '0;
      hand_q      <= '0;
      victim_q    <= '0;
      evict_q     <= 1'b0;
      grp_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q <= in_data_i;
            grp_q <= '0;
            state_q <= (in_data_i.action == ACT_ALLOC) ? S_SCAN : S_OP;
          end
        end

        S_OP: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (req_q.action == ACT_FREE || req_q.action == ACT_MARK) begin
              rsp_q <= cfr_rsp_t'{granted_frame: '0, evicted: 1'b0, victim_page: '0,
                                  victim_owner: '0, status: op_fault};
              if (!op_fault && req_q.action == ACT_FREE) begin
                used_q[req_q.frame_index] <= 1'b0;
                ref_q[req_q.frame_index]  <= 1'b0;
              end else if (!op_fault) begin
                ref_q[req_q.frame_index] <= 1'b1;
              end
            end else begin
              rsp_q <= '0;
            end
          end
        end

        S_SCAN: begin
          if (grp_hit) begin
            victim_q <= {grp_q, grp_sel};
            evict_q  <= 1'b0;
            state_q  <= S_FINISH;
          end else if (grp_q == GSEL_BITS'(NUM_GROUPS - 1)) begin
            state_q <= S_SWEEP;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end

        S_SWEEP: begin
          // second chance: clear a set bit and move on, stop on a clear one
          hand_q <= hand_nxt;
          if (ref_q[hand_nxt]) begin
            ref_q[hand_nxt] <= 1'b0;
          end else begin
            victim_q <= hand_nxt;
            evict_q  <= 1'b1;
            state_q  <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            rsp_q <= cfr_rsp_t'{
              granted_frame: victim_q,
              evicted:       evict_q,
              victim_page:   evict_q ? rd_q[ENTRY_BITS-1:OWNER_BITS] : '0,
              victim_owner:  evict_q ? rd_q[OWNER_BITS-1:0] : '0,
              status:        1'b0
            };
            used_q[victim_q]    <= 1'b1;
            ref_q[victim_q]     <= 1'b0;
            if (evict_q) hand_q <= victim_nxt;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // the sweep only runs with every frame in use
  `ASSERT_IMPL(a_sweep_full, clk_i, rst_ni, state_q == S_SWEEP, &used_q)
  // a grant without eviction always lands on a free frame
  `ASSERT_IMPL(a_grant_free, clk_i, rst_ni, state_q == S_FINISH && !evict_q,
               !used_q[victim_q])
  // an evicted frame sits under the hand with its reference bit clear
  `ASSERT_IMPL(a_victim_hand, clk_i, rst_ni, state_q == S_FINISH && evict_q,
               hand_q == victim_q && !ref_q[victim_q] && used_q[victim_q])
  // a result beat is only loaded into a free output register
  `ASSERT_CLK(a_no_overrun, clk_i, rst_ni,
              $past(out_valid_q && out_stall_i) |-> $stable(rsp_q))

endmodule

`default_nettype wire
